@@ rtl/rpc_pkg.sv @@
`timescale 1ns / 1ps

package rpc_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int ITERATIONS_DEF = 16;

    // fraction bits carried by the coordinates through the iterations
    localparam int GUARD   = 16;
    // angles are fractions of a full turn in this many bits
    localparam int ZW      = 32;
    localparam int TAB_LEN = 32;

    // inverse cordic gain, q32, applied as a split multiply
    localparam logic [31:0] GAIN_Q32  = 32'd2608131496;
    localparam int          GAIN_LO   = 25;
    localparam int          GAIN_HI_SHIFT = 7;

    localparam logic [ZW-1:0] HALF_TURN = 32'h8000_0000;

    typedef enum logic
    {
        FUNC_TO_POLAR = 1'b0,
        FUNC_TO_RECT  = 1'b1
    } rpc_func_t;

    typedef struct packed
    {
        logic      valid;
        rpc_func_t func;
        logic      origin;
    } rpc_ctl_t;

    // atan(2^-idx) as a fraction of a full turn
    function automatic logic [ZW-1:0] atan_angle(input int unsigned idx);
        logic [ZW-1:0] r;
        unique case (idx)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            24: r = 32'd41;
            25: r = 32'd20;
            26: r = 32'd10;
            27: r = 32'd5;
            28: r = 32'd3;
            29: r = 32'd1;
            30: r = 32'd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/rpc_if.sv @@
`timescale 1ns / 1ps

interface rpc_in_if #(
    parameter int DATA_WIDTH = rpc_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic signed [DATA_WIDTH-1:0] coord_a;
    logic signed [DATA_WIDTH-1:0] coord_b;

    modport source (output valid, func, coord_a, coord_b, input ready);
    modport sink   (input valid, func, coord_a, coord_b, output ready);
endinterface

interface rpc_out_if #(
    parameter int DATA_WIDTH = rpc_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH:0]   result_a;
    logic signed [DATA_WIDTH-1:0] result_b;

    modport source (output valid, result_a, result_b, input ready);
    modport sink   (input valid, result_a, result_b, output ready);
endinterface

@@ rtl/rpc_prep.sv @@
`timescale 1ns / 1ps

module rpc_prep #(
    parameter int DATA_WIDTH = rpc_pkg::DATA_WIDTH_DEF,
    localparam int XW = DATA_WIDTH + rpc_pkg::GUARD + 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    rpc_in_if.sink                      point,
    output rpc_pkg::rpc_ctl_t           ctl,
    output logic signed [XW-1:0]        x,
    output logic signed [XW-1:0]        y,
    output logic [rpc_pkg::ZW-1:0]      z,
    input  logic                        ready_dn
);

    localparam int ZW = rpc_pkg::ZW;
    localparam int ZS = ZW - DATA_WIDTH;

    rpc_pkg::rpc_ctl_t          ctl_reg;
    rpc_pkg::rpc_ctl_t          ctl_next;
    logic signed [XW-1:0]       x_reg, x_next;
    logic signed [XW-1:0]       y_reg, y_next;
    logic [ZW-1:0]              z_reg, z_next;
    logic signed [DATA_WIDTH:0] a_ext, b_ext, xs, ys;
    logic [ZW-1:0]              z_in;
    logic                       ready_up;

    assign a_ext = (DATA_WIDTH+1)'(point.coord_a);
    assign b_ext = (DATA_WIDTH+1)'(point.coord_b);
    assign z_in  = ZW'(unsigned'(point.coord_b)) << ZS;

    always_comb
    begin
        ctl_next.valid  = point.valid;
        ctl_next.func   = rpc_pkg::rpc_func_t'(point.func);
        ctl_next.origin = 1'b0;
        xs     = a_ext;
        ys     = b_ext;
        z_next = '0;
        if (ctl_next.func == rpc_pkg::FUNC_TO_POLAR)
        begin
            ctl_next.origin = (a_ext == '0) && (b_ext == '0);
            // left half plane: mirror through the origin, start at pi
            if (a_ext[DATA_WIDTH])
            begin
                xs     = -a_ext;
                ys     = -b_ext;
                z_next = rpc_pkg::HALF_TURN;
            end
        end
        else
        begin
            ys     = '0;
            z_next = z_in;
            // second or third quadrant: rotate by pi and negate magnitude
            if (z_in[ZW-1] ^ z_in[ZW-2])
            begin
                z_next = z_in ^ rpc_pkg::HALF_TURN;
                xs     = -a_ext;
            end
        end
        x_next = XW'(xs) <<< rpc_pkg::GUARD;
        y_next = XW'(ys) <<< rpc_pkg::GUARD;
    end

    assign ready_up    = !ctl_reg.valid || ready_dn;
    assign point.ready = ready_up;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (ready_up)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && point.valid)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign ctl = ctl_reg;
    assign x   = x_reg;
    assign y   = y_reg;
    assign z   = z_reg;

endmodule

@@ rtl/rpc_stage.sv @@
`timescale 1ns / 1ps

module rpc_stage #(
    parameter int DATA_WIDTH = rpc_pkg::DATA_WIDTH_DEF,
    parameter int STAGE_IDX  = 0,
    localparam int XW = DATA_WIDTH + rpc_pkg::GUARD + 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rpc_pkg::rpc_ctl_t           ctl_in,
    input  logic signed [XW-1:0]        x_in,
    input  logic signed [XW-1:0]        y_in,
    input  logic [rpc_pkg::ZW-1:0]      z_in,
    output logic                        ready_up,
    output rpc_pkg::rpc_ctl_t           ctl_out,
    output logic signed [XW-1:0]        x_out,
    output logic signed [XW-1:0]        y_out,
    output logic [rpc_pkg::ZW-1:0]      z_out,
    input  logic                        ready_dn
);

    localparam int ZW = rpc_pkg::ZW;
    localparam logic [ZW-1:0] ATAN = rpc_pkg::atan_angle(STAGE_IDX);

    rpc_pkg::rpc_ctl_t    ctl_reg;
    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic [ZW-1:0]        z_reg, z_next;
    logic signed [XW-1:0] dx, dy;
    logic                 plus;

    // floor shifts; vectoring steers on sign of y, rotation on sign of z
    always_comb
    begin
        dx   = y_in >>> STAGE_IDX;
        dy   = x_in >>> STAGE_IDX;
        plus = (ctl_in.func == rpc_pkg::FUNC_TO_RECT) ? z_in[ZW-1] : !y_in[XW-1];
        if (plus)
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
    end

    assign ready_up = !ctl_reg.valid || ready_dn;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (ready_up)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && ctl_in.valid)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg.valid && !ready_dn) |=>
            (ctl_reg.valid && $stable(x_reg) && $stable(y_reg) && $stable(z_reg)))
        else $error("cordic stage lost its item under stall");

endmodule

@@ rtl/rpc_gain.sv @@
`timescale 1ns / 1ps

module rpc_gain #(
    parameter int DATA_WIDTH = rpc_pkg::DATA_WIDTH_DEF,
    localparam int XW  = DATA_WIDTH + rpc_pkg::GUARD + 3,
    localparam int PHW = XW - rpc_pkg::GAIN_LO + 32,
    localparam int PLW = rpc_pkg::GAIN_LO + 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rpc_pkg::rpc_ctl_t           ctl_in,
    input  logic signed [XW-1:0]        x_in,
    input  logic signed [XW-1:0]        y_in,
    input  logic [rpc_pkg::ZW-1:0]      z_in,
    output logic                        ready_up,
    output rpc_pkg::rpc_ctl_t           ctl_out,
    output logic                        neg_x,
    output logic                        neg_y,
    output logic [PHW-1:0]              hi_x,
    output logic [PLW-1:0]              lo_x,
    output logic [PHW-1:0]              hi_y,
    output logic [PLW-1:0]              lo_y,
    output logic [rpc_pkg::ZW-1:0]      z_out,
    input  logic                        ready_dn
);

    localparam int ZW = rpc_pkg::ZW;
    localparam int LO = rpc_pkg::GAIN_LO;

    rpc_pkg::rpc_ctl_t ctl_reg;
    logic [XW-1:0]     ax, ay;
    logic              neg_x_reg, neg_y_reg;
    logic [PHW-1:0]    hi_x_reg, hi_x_next, hi_y_reg, hi_y_next;
    logic [PLW-1:0]    lo_x_reg, lo_x_next, lo_y_reg, lo_y_next;
    logic [ZW-1:0]     z_reg;

    // magnitude split at bit 25; each part is multiplied by the q32 gain separately
    always_comb
    begin
        ax = x_in[XW-1] ? unsigned'(-x_in) : unsigned'(x_in);
        ay = y_in[XW-1] ? unsigned'(-y_in) : unsigned'(y_in);
        hi_x_next = PHW'(ax[XW-1:LO]) * PHW'(rpc_pkg::GAIN_Q32);
        lo_x_next = PLW'(ax[LO-1:0]) * PLW'(rpc_pkg::GAIN_Q32);
        hi_y_next = PHW'(ay[XW-1:LO]) * PHW'(rpc_pkg::GAIN_Q32);
        lo_y_next = PLW'(ay[LO-1:0]) * PLW'(rpc_pkg::GAIN_Q32);
    end

    assign ready_up = !ctl_reg.valid || ready_dn;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (ready_up)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && ctl_in.valid)
        begin
            neg_x_reg <= x_in[XW-1];
            neg_y_reg <= y_in[XW-1];
            hi_x_reg  <= hi_x_next;
            lo_x_reg  <= lo_x_next;
            hi_y_reg  <= hi_y_next;
            lo_y_reg  <= lo_y_next;
            z_reg     <= z_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign neg_x   = neg_x_reg;
    assign neg_y   = neg_y_reg;
    assign hi_x    = hi_x_reg;
    assign lo_x    = lo_x_reg;
    assign hi_y    = hi_y_reg;
    assign lo_y    = lo_y_reg;
    assign z_out   = z_reg;

endmodule

@@ rtl/rpc_post.sv @@
`timescale 1ns / 1ps

module rpc_post #(
    parameter int DATA_WIDTH = rpc_pkg::DATA_WIDTH_DEF,
    localparam int XW  = DATA_WIDTH + rpc_pkg::GUARD + 3,
    localparam int PHW = XW - rpc_pkg::GAIN_LO + 32,
    localparam int PLW = rpc_pkg::GAIN_LO + 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rpc_pkg::rpc_ctl_t           ctl_in,
    input  logic                        neg_x,
    input  logic                        neg_y,
    input  logic [PHW-1:0]              hi_x,
    input  logic [PLW-1:0]              lo_x,
    input  logic [PHW-1:0]              hi_y,
    input  logic [PLW-1:0]              lo_y,
    input  logic [rpc_pkg::ZW-1:0]      z_in,
    output logic                        ready_up,
    rpc_out_if.source                   result
);

    localparam int ZW = rpc_pkg::ZW;
    localparam int ZS = ZW - DATA_WIDTH;
    localparam int SW = XW + 2;
    localparam logic [ZW:0] Z_RND = (ZW+1)'((64'd1 << ZS) >> 1);
    localparam logic signed [SW-1:0] G_RND = SW'(64'sd1 <<< (rpc_pkg::GUARD - 1));
    localparam logic signed [SW-1:0] A_MAX = SW'((64'sd1 <<< DATA_WIDTH) - 64'sd1);
    localparam logic signed [SW-1:0] A_MIN = SW'(-(64'sd1 <<< DATA_WIDTH));
    localparam logic signed [SW-1:0] B_MAX = SW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] B_MIN = SW'(-(64'sd1 <<< (DATA_WIDTH - 1)));

    logic                         vld_reg;
    logic signed [DATA_WIDTH:0]   a_reg, a_next;
    logic signed [DATA_WIDTH-1:0] b_reg, b_next;
    logic signed [SW-1:0]         rx, ry, sx, sy;
    logic [ZW:0]                  zr;

    // sum partial products, restore sign, drop guard bits rounding half up
    function automatic logic signed [SW-1:0] finish(input logic [PHW-1:0] hi,
                                                     input logic [PLW-1:0] lo,
                                                     input logic neg);
        logic signed [SW-1:0] p;
        p = SW'(hi >> rpc_pkg::GAIN_HI_SHIFT) + SW'(lo >> 32);
        if (neg)
        begin
            p = -p;
        end
        return (p + G_RND) >>> rpc_pkg::GUARD;
    endfunction

    always_comb
    begin
        rx = finish(hi_x, lo_x, neg_x);
        ry = finish(hi_y, lo_y, neg_y);
        sx = (rx > A_MAX) ? A_MAX : ((rx < A_MIN) ? A_MIN : rx);
        sy = (ry > B_MAX) ? B_MAX : ((ry < B_MIN) ? B_MIN : ry);
        zr = ({1'b0, z_in} + Z_RND) >> ZS;
        a_next = sx[DATA_WIDTH:0];
        if (ctl_in.func == rpc_pkg::FUNC_TO_RECT)
        begin
            b_next = sy[DATA_WIDTH-1:0];
        end
        else
        begin
            b_next = zr[DATA_WIDTH-1:0];
        end
        if (ctl_in.origin)
        begin
            a_next = '0;
            b_next = '0;
        end
    end

    assign ready_up = !vld_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            vld_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && ctl_in.valid)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign result.valid    = vld_reg;
    assign result.result_a = a_reg;
    assign result.result_b = b_reg;

    a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_in.valid && ctl_in.origin && ready_up) |=>
            (vld_reg && a_reg == '0 && b_reg == '0))
        else $error("origin point did not give a zero result");

endmodule

@@ rtl/rect_polar_converter.sv @@
`timescale 1ns / 1ps
// channel   dir   fields                               transfer when
// point     in    func, coord_a, coord_b               point.valid && point.ready
// result    out   result_a, result_b                   result.valid && result.ready
//
// one point enters per cycle while point.ready is high; the registered stages are the
// input stage, one registered cordic stage per iteration, gain multiply, round/saturate
// the cordic is unrolled: every iteration has its own adders
// rst_n clears the valid bits of every stage asynchronously; data is not reset
// each stage holds while its successor is full and stalled, bubbles collapse,
// so the input keeps taking points until the whole pipeline is full

module rect_polar_converter #(
    parameter int DATA_WIDTH = rpc_pkg::DATA_WIDTH_DEF,
    parameter int ITERATIONS = rpc_pkg::ITERATIONS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rpc_in_if.sink     point,
    rpc_out_if.source  result
);

    // iteration count is capped by the arctangent table length
    localparam int NSTAGE = (ITERATIONS < rpc_pkg::TAB_LEN) ? ITERATIONS : rpc_pkg::TAB_LEN;
    localparam int XW     = DATA_WIDTH + rpc_pkg::GUARD + 3;
    localparam int PHW    = XW - rpc_pkg::GAIN_LO + 32;
    localparam int PLW    = rpc_pkg::GAIN_LO + 32;
    localparam int ZW     = rpc_pkg::ZW;

    // cordic chain: index k is the output of the stage before iteration k
    rpc_pkg::rpc_ctl_t    cctl [0:NSTAGE];
    logic signed [XW-1:0] cx   [0:NSTAGE];
    logic signed [XW-1:0] cy   [0:NSTAGE];
    logic [ZW-1:0]        cz   [0:NSTAGE];
    logic                 crdy [0:NSTAGE];

    // gain multiply stage outputs
    rpc_pkg::rpc_ctl_t    gctl;
    logic                 gneg_x, gneg_y;
    logic [PHW-1:0]       ghi_x, ghi_y;
    logic [PLW-1:0]       glo_x, glo_y;
    logic [ZW-1:0]        gz;
    logic                 post_rdy;

    // input stage: origin detect, half-plane mirror, quadrant fold
    rpc_prep #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .point    (point),
        .ctl      (cctl[0]),
        .x        (cx[0]),
        .y        (cy[0]),
        .z        (cz[0]),
        .ready_dn (crdy[0])
    );

    // one micro-rotation per stage
    for (genvar k = 0; k < NSTAGE; k++)
    begin : g_iter
        rpc_stage #(
            .DATA_WIDTH (DATA_WIDTH),
            .STAGE_IDX  (k)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl_in   (cctl[k]),
            .x_in     (cx[k]),
            .y_in     (cy[k]),
            .z_in     (cz[k]),
            .ready_up (crdy[k]),
            .ctl_out  (cctl[k+1]),
            .x_out    (cx[k+1]),
            .y_out    (cy[k+1]),
            .z_out    (cz[k+1]),
            .ready_dn ((k + 1 < NSTAGE) ? crdy[k+1] : crdy[NSTAGE])
        );
    end

    // gain compensation, partial products registered
    rpc_gain #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_gain (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (cctl[NSTAGE]),
        .x_in     (cx[NSTAGE]),
        .y_in     (cy[NSTAGE]),
        .z_in     (cz[NSTAGE]),
        .ready_up (crdy[NSTAGE]),
        .ctl_out  (gctl),
        .neg_x    (gneg_x),
        .neg_y    (gneg_y),
        .hi_x     (ghi_x),
        .lo_x     (glo_x),
        .hi_y     (ghi_y),
        .lo_y     (glo_y),
        .z_out    (gz),
        .ready_dn (post_rdy)
    );

    // guard-bit rounding, saturation, angle rounding, output register
    rpc_post #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (gctl),
        .neg_x    (gneg_x),
        .neg_y    (gneg_y),
        .hi_x     (ghi_x),
        .lo_x     (glo_x),
        .hi_y     (ghi_y),
        .lo_y     (glo_y),
        .z_in     (gz),
        .ready_up (post_rdy),
        .result   (result)
    );

    // an empty output register means nothing can be stalled upstream
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !result.valid |-> point.ready)
        else $error("input blocked while output register is empty");

    // every accepted point lands in the input stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (point.valid && point.ready) |=> cctl[0].valid)
        else $error("accepted point missing from input stage");

endmodule
